// File: src/itcc_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the interval table contractor
// no dependencies
package itcc_pkg;

	localparam int VIOL_W = 31;
	localparam logic [VIOL_W-1:0] VIOL_MAX = {VIOL_W{1'b1}};

	typedef enum logic [2:0] {
		ACT_LOAD     = 3'd0,
		ACT_DOMAIN   = 3'd1,
		ACT_CHECK    = 3'd2,
		ACT_VIOL     = 3'd3,
		ACT_CONTRACT = 3'd4
	} action_t;

	localparam logic [1:0] ST_EMPTY = 2'd0;
	localparam logic [1:0] ST_MAYBE = 2'd1;
	localparam logic [1:0] ST_INNER = 2'd2;
	localparam logic [1:0] ST_VIOL  = 2'd3;

	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	// flags that travel with a row down the column chain
	typedef struct packed {
		logic valid;
		logic last;
		logic hull;
		logic cons;
		logic ok;
	} link_t;

endpackage

// File: src/itcc_cell.sv
`timescale 1ns / 1ps
// one column cell: column table memory, domain, hull accumulator, row test
// depends on itcc_pkg
module itcc_cell import itcc_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int BW = 32,
	parameter int RIW = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            active,
	input  link_t           in_link,
	input  logic [RIW-1:0]  in_row,
	input  logic [VIOL_W-1:0] in_worst,
	output link_t           out_link,
	output logic [RIW-1:0]  out_row,
	output logic [VIOL_W-1:0] out_worst,
	input  logic            cell_we,
	input  logic [RIW-1:0]  wr_row,
	input  logic [BW-1:0]   wr_lo,
	input  logic [BW-1:0]   wr_hi,
	input  logic            dom_we,
	input  logic [BW-1:0]   dom_lo,
	input  logic [BW-1:0]   dom_hi,
	input  logic            acc_clr,
	output logic [BW-1:0]   x_lo,
	output logic [BW-1:0]   x_hi,
	output logic            x_empty
);

	localparam int GW = (BW > VIOL_W) ? BW : VIOL_W;

	logic [BW-1:0] mem_lo_q [MAX_ROWS];
	logic [BW-1:0] mem_hi_q [MAX_ROWS];
	logic [BW-1:0] rd_lo_s1, rd_hi_s1;
	link_t link_s1;
	logic [RIW-1:0] row_s1;
	logic [VIOL_W-1:0] worst_s1;
	logic [BW-1:0] dlo_q, dhi_q, acc_lo_q, acc_hi_q;
	logic rev, below, above, dis, inf;
	logic [BW-1:0] sp_a, sp_b, d;
	logic [GW-1:0] dx;
	logic [VIOL_W-1:0] gap;

	always_ff @(posedge clk) begin
		if (cell_we) begin
			mem_lo_q[wr_row] <= wr_lo;
			mem_hi_q[wr_row] <= wr_hi;
		end
	end

	always_ff @(posedge clk) begin
		rd_lo_s1 <= mem_lo_q[in_row];
		rd_hi_s1 <= mem_hi_q[in_row];
		row_s1 <= in_row;
		worst_s1 <= in_worst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_s1 <= '0;
		end else begin
			link_s1 <= in_link;
		end
	end

	// gap between domain and cell, offset binary so unsigned order holds
	always_comb begin
		rev = (dlo_q > dhi_q) || (rd_lo_s1 > rd_hi_s1);
		below = dhi_q < rd_lo_s1;
		above = rd_hi_s1 < dlo_q;
		dis = rev || below || above;
		sp_a = below ? dhi_q : rd_hi_s1;
		sp_b = below ? rd_lo_s1 : dlo_q;
		inf = (sp_a == '0) || (sp_a == '1) || (sp_b == '0) || (sp_b == '1);
		d = sp_b - sp_a;
		dx = GW'(d);
		if (rev) begin
			gap = VIOL_MAX;
		end else if (below || above) begin
			gap = (inf || (dx > GW'(VIOL_MAX))) ? VIOL_MAX : VIOL_W'(dx);
		end else begin
			gap = '0;
		end
	end

	always_ff @(posedge clk) begin
		out_row <= row_s1;
		out_worst <= (active && gap > worst_s1) ? gap : worst_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_link <= '0;
			dlo_q <= '0;
			dhi_q <= '1;
			acc_lo_q <= '1;
			acc_hi_q <= '0;
		end else begin
			out_link.valid <= link_s1.valid;
			out_link.last <= link_s1.last;
			out_link.hull <= link_s1.hull;
			out_link.cons <= link_s1.cons;
			out_link.ok <= link_s1.ok & (~active | ~dis);
			if (dom_we) begin
				dlo_q <= dom_lo;
				dhi_q <= dom_hi;
			end
			if (acc_clr) begin
				acc_lo_q <= '1;
				acc_hi_q <= '0;
			end else if (link_s1.valid && link_s1.hull && link_s1.cons) begin
				if (rd_lo_s1 < acc_lo_q) acc_lo_q <= rd_lo_s1;
				if (rd_hi_s1 > acc_hi_q) acc_hi_q <= rd_hi_s1;
			end
		end
	end

	assign x_lo = (acc_lo_q > dlo_q) ? acc_lo_q : dlo_q;
	assign x_hi = (acc_hi_q < dhi_q) ? acc_hi_q : dhi_q;
	assign x_empty = x_lo > x_hi;

endmodule

// File: src/interval_table_constraint_contractor.sv
`timescale 1ns / 1ps
// interval table contractor top: request sequencer, column cell chain, result register
// depends on itcc_pkg and itcc_cell
//
// Requests arrive on in_valid / in_stall; results leave on out_valid / out_stall.
// Cell loads and domain sets give no result.
// Check and violation walk the rows in use once down a chain of column cells;
// each cell holds a row in its read register, then its result register; after the
// last row leaves the chain the result is registered via S_POST and S_REPORT.
// Contract walks the rows twice (consistency, then hull) if any row is consistent,
// else it gives one report as check does; after the hull pass it gives one result per
// column in use, one per cycle while out_stall is low, stopping at an empty column.
// Only one request is in flight: in_stall is high until the last result of the
// current request has been loaded into the output register.
// While out_stall is high with a result held, the output register keeps it and the
// sequencer waits to emit. Configuration is written through cfg_we / cfg_index /
// cfg_data; the user must write it only while idle, the block itself does not enforce
// this. Reset clears the domains to the whole line, the row marks to zero and the
// row and column counts to one; table cells hold nothing until loaded.
module interval_table_constraint_contractor import itcc_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 8,
	parameter int BOUND_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [5:0]  row_index,
	input  logic [2:0]  col_index,
	input  logic signed [31:0] bound_low,
	input  logic signed [31:0] bound_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [2:0]  out_col,
	output logic signed [31:0] dom_low,
	output logic signed [31:0] dom_high,
	output logic [30:0] violation_amount,
	output logic        last
);

	localparam int BW = BOUND_WIDTH;
	localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int CCW = $clog2(MAX_COLS + 1);
	localparam int RXW = (RCW > 7) ? RCW : 7;
	localparam int CXW = (CCW > 4) ? CCW : 4;
	localparam logic [BW-1:0] SIGN = {1'b1, {(BW-1){1'b0}}};

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_POST, S_HULL, S_EMIT, S_REPORT
	} state_t;

	state_t state_q;
	action_t op_q;
	logic [6:0] rows_q;
	logic [3:0] cols_q;
	logic [RXW-1:0] rows_x;
	logic [CXW-1:0] cols_x;
	logic [RCW-1:0] rows_eff;
	logic [CCW-1:0] cols_eff;
	logic [RIW-1:0] rows_last, irow_q;
	logic [CIW-1:0] cols_last, col_q;
	logic issue_q;
	logic [1:0] cnt_q;
	logic [VIOL_W-1:0] best_q;
	logic [MAX_ROWS-1:0] cons_q;
	logic accept, out_free, out_load, row_ok, col_ok;
	logic [BW-1:0] lo_in, hi_in, dom_lo_bus, dom_hi_bus;

	link_t link [MAX_COLS+1];
	logic [RIW-1:0] lrow [MAX_COLS+1];
	logic [VIOL_W-1:0] lworst [MAX_COLS+1];
	logic [BW-1:0] xl [MAX_COLS];
	logic [BW-1:0] xh [MAX_COLS];
	logic [MAX_COLS-1:0] xe, cell_we, dom_we;
	logic [BW-1:0] sel_lo, sel_hi;
	logic sel_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd1;
			cols_q <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROWS: rows_q <= cfg_data;
				CFG_COLS: cols_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// clamp counts to the storage and raise a count of zero to one
	always_comb begin
		rows_x = RXW'(rows_q);
		cols_x = CXW'(cols_q);
		if (rows_x == '0) rows_eff = RCW'(1);
		else if (rows_x > RXW'(MAX_ROWS)) rows_eff = RCW'(MAX_ROWS);
		else rows_eff = RCW'(rows_x);
		if (cols_x == '0) cols_eff = CCW'(1);
		else if (cols_x > CXW'(MAX_COLS)) cols_eff = CCW'(MAX_COLS);
		else cols_eff = CCW'(cols_x);
		rows_last = RIW'(rows_eff - RCW'(1));
		cols_last = CIW'(cols_eff - CCW'(1));
	end

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign out_load = out_free && (state_q == S_EMIT || state_q == S_REPORT);
	assign lo_in = BW'($unsigned(bound_low)) ^ SIGN;
	assign hi_in = BW'($unsigned(bound_high)) ^ SIGN;
	assign row_ok = 11'(row_index) < 11'(MAX_ROWS);
	assign col_ok = 5'(col_index) < 5'(MAX_COLS);

	assign sel_lo = xl[col_q];
	assign sel_hi = xh[col_q];
	assign sel_empty = xe[col_q];

	always_comb begin
		dom_lo_bus = (state_q == S_EMIT) ? sel_lo : lo_in;
		dom_hi_bus = (state_q == S_EMIT) ? sel_hi : hi_in;
		for (int j = 0; j < MAX_COLS; j++) begin
			cell_we[j] = accept && action_t'(action) == ACT_LOAD && row_ok
				&& 5'(col_index) == 5'(j);
			dom_we[j] = (accept && action_t'(action) == ACT_DOMAIN && col_ok
				&& 5'(col_index) == 5'(j))
				|| (state_q == S_EMIT && out_free && !sel_empty && col_q == CIW'(j));
		end
	end

	// chain head
	always_comb begin
		link[0].valid = issue_q && (state_q == S_SCAN || state_q == S_HULL);
		link[0].last = (irow_q == rows_last);
		link[0].hull = (state_q == S_HULL);
		link[0].cons = cons_q[irow_q];
		link[0].ok = 1'b1;
		lrow[0] = irow_q;
		lworst[0] = '0;
	end

	for (genvar j = 0; j < MAX_COLS; j++) begin : g_cell
		itcc_cell #(
			.MAX_ROWS(MAX_ROWS),
			.BW(BW),
			.RIW(RIW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.active(CCW'(j) < cols_eff),
			.in_link(link[j]),
			.in_row(lrow[j]),
			.in_worst(lworst[j]),
			.out_link(link[j+1]),
			.out_row(lrow[j+1]),
			.out_worst(lworst[j+1]),
			.cell_we(cell_we[j]),
			.wr_row(RIW'(row_index)),
			.wr_lo(lo_in),
			.wr_hi(hi_in),
			.dom_we(dom_we[j]),
			.dom_lo(dom_lo_bus),
			.dom_hi(dom_hi_bus),
			.acc_clr(state_q == S_POST),
			.x_lo(xl[j]),
			.x_hi(xh[j]),
			.x_empty(xe[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= ACT_CHECK;
			issue_q <= 1'b0;
			irow_q <= '0;
			cnt_q <= '0;
			best_q <= VIOL_MAX;
			cons_q <= '0;
			col_q <= '0;
			out_valid <= 1'b0;
			status <= ST_EMPTY;
			out_col <= '0;
			dom_low <= '0;
			dom_high <= '0;
			violation_amount <= '0;
			last <= 1'b0;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && (action_t'(action) == ACT_CHECK
						|| action_t'(action) == ACT_VIOL
						|| action_t'(action) == ACT_CONTRACT)) begin
						op_q <= action_t'(action);
						state_q <= S_SCAN;
						issue_q <= 1'b1;
						irow_q <= '0;
						cnt_q <= '0;
						best_q <= VIOL_MAX;
					end
				end
				S_SCAN, S_HULL: begin
					if (issue_q) begin
						irow_q <= irow_q + RIW'(1);
						if (irow_q == rows_last) issue_q <= 1'b0;
					end
					if (link[MAX_COLS].valid) begin
						if (state_q == S_SCAN) begin
							// every row in use gets its mark rewritten
							cons_q[lrow[MAX_COLS]] <= link[MAX_COLS].ok;
							if (link[MAX_COLS].ok && cnt_q != 2'd2) cnt_q <= cnt_q + 2'd1;
							if (lworst[MAX_COLS] < best_q) best_q <= lworst[MAX_COLS];
						end
						if (link[MAX_COLS].last) begin
							state_q <= (state_q == S_SCAN) ? S_POST : S_EMIT;
							col_q <= '0;
						end
					end
				end
				S_POST: begin
					if (op_q == ACT_CONTRACT && cnt_q != 2'd0) begin
						state_q <= S_HULL;
						issue_q <= 1'b1;
						irow_q <= '0;
					end else begin
						state_q <= S_REPORT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_col <= 3'(col_q);
						violation_amount <= '0;
						if (sel_empty) begin
							status <= ST_EMPTY;
							dom_low <= '0;
							dom_high <= '0;
							last <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							status <= (cnt_q == 2'd1) ? ST_INNER : ST_MAYBE;
							dom_low <= 32'(sel_lo ^ SIGN);
							dom_high <= 32'(sel_hi ^ SIGN);
							last <= (col_q == cols_last);
							if (col_q == cols_last) state_q <= S_IDLE;
							else col_q <= col_q + CIW'(1);
						end
					end
				end
				S_REPORT: begin
					if (out_free) begin
						out_col <= '0;
						dom_low <= '0;
						dom_high <= '0;
						last <= 1'b1;
						if (op_q == ACT_VIOL) begin
							status <= ST_VIOL;
							violation_amount <= best_q;
						end else begin
							violation_amount <= '0;
							if (cnt_q == 2'd0) status <= ST_EMPTY;
							else if (cnt_q == 2'd1) status <= ST_INNER;
							else status <= ST_MAYBE;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
